FILE: src/swm_pkg.sv
package swm_pkg;

    localparam int WINDOW_MAX   = 32;
    localparam int SAMPLE_WIDTH = 32;

    // window_size register as listed in the register map
    localparam int WSIZE_W = 6;
    localparam int CNT_W   = $clog2(WINDOW_MAX + 1);
    localparam int IDX_W   = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;

    localparam int ADDR_W  = 3;
    localparam int DATA_W  = 32;

    // register indexes
    localparam logic [ADDR_W-3:0] REG_WINDOW_SIZE = '0;

    localparam logic [WSIZE_W-1:0] WSIZE_RESET = WSIZE_W'(32);

    typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;

    // values every cell sees in the same cycle
    typedef struct packed {
        sample_t x;     // incoming sample
        sample_t old;   // sample leaving the window
        logic    full;  // window full: one entry is evicted
        logic    load;  // a sample is taken this cycle
    } swm_bcast_t;

    // what a cell shows its neighbours
    typedef struct packed {
        sample_t val;   // sorted entry
        sample_t arr;   // arrival-order tap
        sample_t nxt;   // sorted entry after this update
        logic    lt;    // valid and below the new sample
        logic    rm;    // evicted entry sits at or below this cell
        logic    c;     // entry left here after eviction is below the new sample
    } swm_link_t;

    // effective window length: zero acts as one, clamped to WINDOW_MAX
    function automatic logic [CNT_W-1:0] swm_eff_size(input logic [WSIZE_W-1:0] ws);
        logic [CNT_W-1:0] r;
        if (ws == '0)
            r = CNT_W'(1);
        else if (int'(ws) > WINDOW_MAX)
            r = CNT_W'(WINDOW_MAX);
        else
            r = CNT_W'(ws);
        return r;
    endfunction

endpackage

FILE: src/swm_cell.sv
module swm_cell
    import swm_pkg::*;
(
    input  logic       clk,
    input  logic       valid,
    input  swm_bcast_t bc,
    input  swm_link_t  left,
    input  swm_link_t  right,
    output swm_link_t  link
);

    sample_t val_reg, val_next;
    sample_t arr_reg;
    logic    lt, rm, c;
    sample_t r_here, r_left;

    always_comb
    begin
        lt = valid && (val_reg < bc.x);
        rm = bc.full ? (!valid || (val_reg >= bc.old)) : !valid;
        c  = rm ? right.lt : lt;
        // window with the evicted entry taken out, at this place and the one below
        r_here = rm ? right.val : val_reg;
        r_left = left.rm ? val_reg : left.val;
        if (c)
            val_next = r_here;
        else if (left.c)
            val_next = bc.x;
        else
            val_next = r_left;
    end

    always_ff @(posedge clk)
    begin
        if (bc.load)
        begin
            val_reg <= val_next;
            arr_reg <= left.arr;
        end
    end

    always_comb
    begin
        link.val = val_reg;
        link.arr = arr_reg;
        link.nxt = val_next;
        link.lt  = lt;
        link.rm  = rm;
        link.c   = c;
    end

endmodule

FILE: src/sliding_window_median.sv
// The median is registered and appears on m_tvalid/m_tdata in the cycle after the input transfer.
// Throughput: 1 sample per cycle; every cell inserts and evicts in parallel, and the
//   output register frees s_tready again as soon as its median is taken.
// No median is given for the first k-1 samples after reset or a window_size write
//   (k: window_size, 0 read as 1, clamped to 32); the k-th sample gives the first one.
// Reset (rst_n low, asynchronous) empties the window and sets window_size to 32;
//   stored samples are not cleared and are never read before they are written.
module sliding_window_median
    import swm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    // sample stream in
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [31:0]       s_tdata,   // [31:0] sample
    // median stream out
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [31:0]       m_tdata,   // [31:0] median
    // configuration
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    logic [WSIZE_W-1:0] wsize_reg;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               out_valid_reg;
    sample_t            median_reg;

    logic               cfg_wr;
    logic               reg_hit;
    logic               s_fire;
    logic [CNT_W-1:0]   k;
    logic [CNT_W-1:0]   km1;
    logic [CNT_W-1:0]   half;
    logic               full;
    logic               produce;

    swm_bcast_t         bc;
    swm_link_t          cell_o  [WINDOW_MAX];
    swm_link_t          left_i  [WINDOW_MAX];
    swm_link_t          right_i [WINDOW_MAX];
    logic [WINDOW_MAX-1:0] valid;

    // ---------------------------------------------------------------
    // Configuration port: one register, writes restart the fill
    // ---------------------------------------------------------------
    assign pready  = 1'b1;
    assign reg_hit = (paddr[ADDR_W-1:2] == REG_WINDOW_SIZE);
    assign cfg_wr  = psel && penable && pwrite && reg_hit;

    always_comb
    begin
        prdata = '0;
        if (reg_hit)
            prdata = DATA_W'(wsize_reg);
    end

    // ---------------------------------------------------------------
    // Window bookkeeping
    // ---------------------------------------------------------------
    assign k       = swm_eff_size(wsize_reg);
    assign km1     = k - CNT_W'(1);
    assign half    = km1 >> 1;
    assign full    = (cnt_reg == k);
    // a median is due once this transfer completes the window
    assign produce = full || ((cnt_reg + CNT_W'(1)) == k);

    assign s_tready = !out_valid_reg || m_tready;
    assign s_fire   = s_tvalid && s_tready;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (cfg_wr)
            cnt_next = '0;
        else if (s_fire && !full)
            cnt_next = cnt_reg + CNT_W'(1);
    end

    // oldest sample sits at tap k-1 of the arrival line
    always_comb
    begin
        bc.x    = sample_t'(s_tdata[SAMPLE_WIDTH-1:0]);
        bc.old  = cell_o[km1[IDX_W-1:0]].arr;
        bc.full = full;
        bc.load = s_fire;
    end

    // ---------------------------------------------------------------
    // Cell chain: sorted entries ascending from cell 0
    // ---------------------------------------------------------------
    always_comb
    begin
        for (int i = 0; i < WINDOW_MAX; i++)
        begin
            valid[i] = (CNT_W'(i) < cnt_reg);
            if (i == 0)
            begin
                // nothing below the first cell: new sample lands here unless
                // the entry left here is smaller
                left_i[i]     = cell_o[i];
                left_i[i].arr = bc.x;
                left_i[i].rm  = 1'b0;
                left_i[i].c   = 1'b1;
            end
            else
                left_i[i] = cell_o[i-1];
            if (i == WINDOW_MAX - 1)
            begin
                right_i[i]    = cell_o[i];
                right_i[i].lt = 1'b0;
            end
            else
                right_i[i] = cell_o[i+1];
        end
    end

    for (genvar g = 0; g < WINDOW_MAX; g++)
    begin : g_cell
        swm_cell u_cell (
            .clk   (clk),
            .valid (valid[g]),
            .bc    (bc),
            .left  (left_i[g]),
            .right (right_i[g]),
            .link  (cell_o[g])
        );
    end

    // ---------------------------------------------------------------
    // Control registers and output stage
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wsize_reg     <= WSIZE_RESET;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr)
                wsize_reg <= pwdata[WSIZE_W-1:0];
            cnt_reg <= cnt_next;
            if (s_fire && produce)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // lower median: rank (k-1)/2 of the updated window
    always_ff @(posedge clk)
    begin
        if (s_fire && produce)
            median_reg <= cell_o[half[IDX_W-1:0]].nxt;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = 32'(median_reg);

`ifndef SYNTH
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= k)
        else $error("fill count beyond window length");

    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(s_fire))
        else $error("median shown without an input transfer");

    a_full_emits: assert property (@(posedge clk) disable iff (!rst_n)
        (s_fire && full) |=> m_tvalid)
        else $error("full window gave no median");

    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_wr |=> (cnt_reg == '0))
        else $error("window_size write did not restart the fill");
`endif

endmodule

FILE: sim/tb_sliding_window_median.sv
`timescale 1ns / 100ps

// Lower-median filter testbench.
// Samples go in over the slave stream, medians come back over the master stream,
// window_size is set over the APB port. A behavioural copy of the window (an
// arrival ring, re-sorted on every full step) predicts each median; the monitor
// checks every median transfer against the oldest prediction.
module tb_sliding_window_median;
    import swm_pkg::*;

    localparam int      CYCLE_LIMIT  = 200000;  // far above the slowest legal run
    localparam int      DRAIN_CYCLES = 4;       // settling after the queue drains; the median output is registered
    localparam int      IDLE_PCT     = 36;      // idle cycles per hundred, each side
    localparam sample_t S_MIN        = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
    localparam sample_t S_MAX        = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};

    // ports; every input is known from time zero
    logic              clk      = 1'b0;
    logic              rst_n    = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [31:0]       s_tdata  = '0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [31:0]       m_tdata;
    logic              psel     = 1'b0;
    logic              penable  = 1'b0;
    logic              pwrite   = 1'b0;
    logic [ADDR_W-1:0] paddr    = '0;
    logic [DATA_W-1:0] pwdata   = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    // window model
    logic [WSIZE_W-1:0] wsize_reg;
    sample_t            win_ring [WINDOW_MAX];
    int                 held;       // samples in the window
    int                 ring_pos;   // oldest slot, also the next one written

    // predicted medians, oldest first
    sample_t median_q [$];

    // bookkeeping
    bit          quiet = 1'b0;      // both sides stop idling while set
    int          mismatches    = 0;
    int          samples_sent  = 0;
    int          medians_seen  = 0;
    int          size_writes   = 0;
    int          cycle_count   = 0;
    logic [31:0] oldest_median;

    sliding_window_median u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),    // [31:0] sample
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),    // [31:0] median
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #5 clk = ~clk;

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d medians still pending",
                     cycle_count, median_q.size());
            $display("[sliding_window_median] ERROR");
            $finish;
        end
    end

    // receiver: random back-pressure unless a quiet stretch is running
    always @(posedge clk)
        m_tready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);

    task automatic note_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch on %s: expected %0d (0x%08h), got %0d (0x%08h)",
                     what, $signed(want), want, $signed(got), got);
    endtask

    // median monitor; handshake values are the ones held just before the edge
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            medians_seen++;
            if (median_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("median %0d transferred with none pending", $signed(m_tdata));
            end
            else
            begin
                oldest_median = median_q.pop_front();
                if (m_tdata !== oldest_median)
                    note_mismatch("median", oldest_median, m_tdata);
            end
        end
    end

    // ---------------------------------------------------------------- model

    function automatic int eff_window();
        int w;
        w = int'(wsize_reg);
        if (w == 0)
            w = 1;                  // zero behaves as a single tap
        else if (w > WINDOW_MAX)
            w = WINDOW_MAX;         // clamp
        return w;
    endfunction

    function automatic sample_t window_lower_median(input int k);
        sample_t srt [WINDOW_MAX];
        sample_t v;
        int      j;
        for (int i = 0; i < k; i++)
            srt[i] = win_ring[i];
        for (int i = 1; i < k; i++)
        begin
            v = srt[i];
            j = i - 1;
            while (j >= 0 && srt[j] > v)
            begin
                srt[j + 1] = srt[j];
                j--;
            end
            srt[j + 1] = v;
        end
        return srt[(k - 1) / 2];
    endfunction

    // one accepted sample: overwrite the oldest slot, predict once full
    function automatic void window_take(input sample_t x);
        int k;
        k = eff_window();
        if (ring_pos >= k)
            ring_pos = 0;
        if (held > k)
            held = k;
        win_ring[ring_pos] = x;
        if (held < k)
            held++;
        ring_pos++;
        if (ring_pos >= k)
            ring_pos = 0;
        if (held == k)
            median_q.insert(median_q.size(), window_lower_median(k));
    endfunction

    // ------------------------------------------------------------ drivers

    // one sample transfer; valid is only lowered for a gap, never between
    // back-to-back transfers
    task automatic send_sample(input sample_t x);
        while (!quiet && $urandom_range(0, 99) < IDLE_PCT)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= x;
        do
            @(posedge clk);
        while (!s_tready);
        window_take(x);
        samples_sent++;
    endtask

    // stop sending, let every pending median out, then let the pipe settle
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (median_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // window_size write; junk above bit 5 must be ignored. Always restarts the fill.
    task automatic write_window_size(input logic [WSIZE_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_WINDOW_SIZE, 2'b00};
        pwdata  <= (DATA_W'($urandom) & ~DATA_W'({WSIZE_W{1'b1}})) | DATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        wsize_reg = value;
        held      = 0;
        ring_pos  = 0;
        size_writes++;
        @(posedge clk);
    endtask

    task automatic check_window_size();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {REG_WINDOW_SIZE, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata !== DATA_W'(wsize_reg))
            note_mismatch("window_size readback", DATA_W'(wsize_reg), prdata);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // mixed content: extremes, a narrow band full of duplicates, full range
    function automatic sample_t pick_sample();
        case ($urandom_range(0, 9))
            0:
                case ($urandom_range(0, 3))
                    0:       return S_MIN;
                    1:       return S_MAX;
                    2:       return '0;
                    default: return '1;
                endcase
            1, 2, 3: return sample_t'(int'($urandom_range(0, 8)) - 4);
            default: return sample_t'($urandom);
        endcase
    endfunction

    // ------------------------------------------------------------- tests

    task automatic test_reset_state();
        check_window_size();
    endtask

    // reset window of 32, never written; one drain part way through
    task automatic test_default_window();
        for (int i = 0; i < 80; i++)
        begin
            if (i == 45)
                wait_drained();
            send_sample(pick_sample());
        end
    endtask

    // single tap: every sample comes straight back, extremes included
    task automatic test_single_tap();
        wait_drained();
        write_window_size(WSIZE_W'(1));
        check_window_size();
        send_sample(S_MIN);
        send_sample(S_MAX);
        send_sample('0);
        send_sample('1);
        send_sample(sample_t'(1));
        send_sample(sample_t'(32'h5555_5555));
        send_sample(sample_t'(32'hAAAA_AAAA));
    endtask

    // size zero behaves as one
    task automatic test_zero_window();
        wait_drained();
        write_window_size('0);
        check_window_size();
        send_sample(sample_t'(-17));
        send_sample(S_MAX);
        send_sample(sample_t'(42));
    endtask

    // duplicates in the window: evicting one of several equal entries
    task automatic test_equal_samples();
        wait_drained();
        write_window_size(WSIZE_W'(3));
        send_sample(sample_t'(7));
        send_sample(sample_t'(7));
        send_sample(sample_t'(7));
        send_sample(sample_t'(-2));
        send_sample(sample_t'(7));
        send_sample(sample_t'(7));
        send_sample(sample_t'(-2));
        send_sample(sample_t'(-2));
    endtask

    // rewriting the same size part way through the fill empties the window
    task automatic test_restart();
        wait_drained();
        write_window_size(WSIZE_W'(4));
        send_sample(S_MAX);
        send_sample(S_MAX);
        wait_drained();
        write_window_size(WSIZE_W'(4));
        check_window_size();
        for (int i = 0; i < 5; i++)
            send_sample(sample_t'(int'(i) - 2));
    endtask

    // sizes above the window depth clamp to it
    task automatic test_oversize();
        wait_drained();
        write_window_size('1);
        check_window_size();
        for (int i = 0; i < 45; i++)
            send_sample(pick_sample());
        wait_drained();
        write_window_size(WSIZE_W'(WINDOW_MAX + 1));
        for (int i = 0; i < 40; i++)
            send_sample(pick_sample());
    endtask

    // many settings, mostly small windows; random, ramp and restart content
    task automatic test_random_windows();
        logic [WSIZE_W-1:0] ws;
        int                 n;
        int                 mode;
        int                 cut;
        sample_t            ramp;
        for (int ph = 0; ph < 16; ph++)
        begin
            wait_drained();
            case ($urandom_range(0, 5))
                0:       ws = WSIZE_W'($urandom_range(0, 63));
                1:       ws = WSIZE_W'($urandom_range(17, 32));
                default: ws = WSIZE_W'($urandom_range(1, 9));
            endcase
            write_window_size(ws);
            if ($urandom_range(0, 2) == 0)
                check_window_size();
            n    = eff_window() + $urandom_range(15, 45);
            mode = $urandom_range(0, 5);
            cut  = $urandom_range(0, n - 1);
            ramp = sample_t'($urandom);
            for (int i = 0; i < n; i++)
            begin
                if (i == cut && mode == 4)
                begin
                    // sender holds off until every median is back
                    wait_drained();
                end
                else if (i == cut && mode == 5)
                begin
                    // restart mid-stream with the same size
                    wait_drained();
                    write_window_size(ws);
                end
                if (mode == 1)
                begin
                    send_sample(ramp);
                    ramp = ramp + sample_t'($urandom_range(0, 3));
                end
                else if (mode == 2)
                begin
                    send_sample(ramp);
                    ramp = ramp - sample_t'($urandom_range(0, 3));
                end
                else
                    send_sample(pick_sample());
            end
        end
    endtask

    // long stretch at full rate on both sides
    task automatic test_full_rate();
        wait_drained();
        write_window_size(WSIZE_W'(5));
        quiet = 1'b1;
        for (int i = 0; i < 150; i++)
            send_sample(pick_sample());
        wait_drained();
        quiet = 1'b0;
    endtask

    initial
    begin
        wsize_reg = WSIZE_RESET;
        held      = 0;
        ring_pos  = 0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_default_window();
        test_single_tap();
        test_zero_window();
        test_equal_samples();
        test_restart();
        test_oversize();
        test_random_windows();
        test_full_rate();
        wait_drained();

        $display("covered %0d samples and %0d medians over %0d window_size writes",
                 samples_sent, medians_seen, size_writes);
        $display("sizes 0, 1, small, 32 and clamped, with restarts, drains and back-pressure");
        if (mismatches == 0)
            $display("[sliding_window_median] OK");
        else
        begin
            $display("%0d mismatches", mismatches);
            $display("[sliding_window_median] ERROR");
        end
        $finish;
    end

endmodule

FILE: sim.f
src/swm_pkg.sv
src/swm_cell.sv
src/sliding_window_median.sv
sim/tb_sliding_window_median.sv
